/* hw/rtl/sktab_pkg.sv */
// shared types and codes for the sorted key table
package sktab_pkg;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_FIND   = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [15:0] entry_key;
    logic [7:0]  entry_handle;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] found_handle;
    logic [3:0] position;
  } result_t;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  handle;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       rd_search;
    logic       rd_shift;
    logic       idx_inc;
    logic       ptr_init;
    logic       shift_wr;
    logic       ins_wr;
    logic       emit;
    logic [2:0] code;
  } cmd_t;

  typedef struct packed {
    logic is_find;
    logic idx_lt_count;
    logic key_lt;
    logic key_eq;
    logic full;
    logic ptr_gt_idx;
  } stat_t;

endpackage

/* hw/rtl/sktab_ctrl.sv */
// controller state machine for the sorted key table
module sktab_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sktab_pkg::stat_t  stat,
  output sktab_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SRCH_RD  = 3'd1;
  localparam logic [2:0] S_SRCH_CMP = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_WRITE    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       decide;
  logic       hit;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.code   = sktab_pkg::ST_INSERTED;
    state_next = state;
    decide     = 1'b0;
    hit        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (stat.idx_lt_count) begin
          cmd.rd_search = 1'b1;
          state_next    = S_SRCH_CMP;
        end else begin
          decide = 1'b1;
        end
      end
      S_SRCH_CMP: begin
        if (stat.key_lt) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SRCH_RD;
        end else begin
          decide = 1'b1;
          hit    = stat.key_eq;
        end
      end
      S_SHIFT_RD: begin
        if (stat.ptr_gt_idx) begin
          cmd.rd_shift = 1'b1;
          state_next   = S_SHIFT_WR;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_WRITE: begin
        cmd.ins_wr = 1'b1;
        cmd.emit   = 1'b1;
        cmd.code   = sktab_pkg::ST_INSERTED;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (decide) begin
      if (stat.is_find) begin
        cmd.emit   = 1'b1;
        cmd.code   = hit ? sktab_pkg::ST_FOUND : sktab_pkg::ST_NOT_FOUND;
        state_next = S_IDLE;
      end else if (hit) begin
        cmd.emit   = 1'b1;
        cmd.code   = sktab_pkg::ST_DUPLICATE;
        state_next = S_IDLE;
      end else if (stat.full) begin
        cmd.emit   = 1'b1;
        cmd.code   = sktab_pkg::ST_FULL;
        state_next = S_IDLE;
      end else begin
        cmd.ptr_init = 1'b1;
        state_next   = S_SHIFT_RD;
      end
    end
  end

endmodule

/* hw/rtl/sktab_dpath.sv */
// datapath of the sorted key table: entry memory, counters and result register
module sktab_dpath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  sktab_pkg::item_t    item,
  input  sktab_pkg::cmd_t     cmd,
  output sktab_pkg::stat_t    stat,
  output logic                done,
  output sktab_pkg::result_t  result
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  sktab_pkg::entry_t mem [TABLE_DEPTH];
  sktab_pkg::entry_t rdata;
  sktab_pkg::item_t  cur;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     ptr_m1;
  logic [CW-1:0]     count;
  logic [CW+3:0]     idx_wide;
  logic [AW-1:0]     rd_addr;

  assign ptr_m1   = ptr - CW'(1);
  assign idx_wide = {4'b0000, idx};
  assign rd_addr  = cmd.rd_shift ? ptr_m1[AW-1:0] : idx[AW-1:0];

  assign stat.is_find      = (cur.kind == sktab_pkg::KIND_FIND);
  assign stat.idx_lt_count = (idx < count);
  assign stat.key_lt       = (rdata.key < cur.entry_key);
  assign stat.key_eq       = (rdata.key == cur.entry_key);
  assign stat.full         = (count == CW'(TABLE_DEPTH));
  assign stat.ptr_gt_idx   = (ptr > idx);

  // entry memory
  always_ff @(posedge clk) begin
    if (cmd.rd_search || cmd.rd_shift) begin
      rdata <= mem[rd_addr];
    end
    if (cmd.shift_wr) begin
      mem[ptr[AW-1:0]] <= rdata;
    end else if (cmd.ins_wr) begin
      mem[idx[AW-1:0]] <= '{key: cur.entry_key, handle: cur.entry_handle};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
    end
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end
    if (cmd.ptr_init) begin
      ptr <= count;
    end else if (cmd.shift_wr) begin
      ptr <= ptr_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.ins_wr) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status       <= cmd.code;
      result.found_handle <= (cmd.code == sktab_pkg::ST_FOUND) ? rdata.handle : 8'd0;
      result.position     <= (cmd.code == sktab_pkg::ST_FOUND ||
                              cmd.code == sktab_pkg::ST_INSERTED) ? idx_wide[3:0] : 4'd0;
    end
  end

endmodule

/* hw/rtl/sorted_key_table_top.sv */
// top level of the sorted key table
//
// keeps up to TABLE_DEPTH entries (16-bit key, 8-bit handle) in ascending key order
// command channel: an item (kind, entry_key, entry_handle) is taken at a clock
// edge with start high and busy low; busy stays high until the result is issued
// result channel: done is high for exactly one cycle with status, found_handle
// and position on result; the receiver takes it in that cycle and cannot stall
// search: entries are read one at a time through the registered memory read port,
// each in a read state (SRCH_RD) and a compare state (SRCH_CMP); an insert then
// moves each larger entry up by one (SHIFT_RD, SHIFT_WR), then makes a final
// check (SHIFT_RD) and writes the new entry (WRITE)
// a new command may be given in the cycle that done is high
// reset clears the entry count and the controller; the memory keeps its
// contents but nothing beyond the count is ever read
module sorted_key_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sktab_pkg::item_t    item,
  output logic                done,
  output sktab_pkg::result_t  result
);

  sktab_pkg::cmd_t  cmd;
  sktab_pkg::stat_t stat;

  sktab_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  sktab_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

/* tb/sv/testbench.sv */
// testbench for the sorted key table: ordered inserts, lookups, duplicates and a full table
`timescale 1ns / 100ps

module testbench;

  localparam int TABLE_DEPTH = 16;
  localparam int SETTLE_CYCLES = 4 * TABLE_DEPTH + 8;
  localparam int LOOKUP_ITEMS = 1230;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic               done;
  sktab_pkg::item_t   item;
  sktab_pkg::result_t result;

  logic [15:0]        table_keys [TABLE_DEPTH];
  logic [7:0]         table_handles [TABLE_DEPTH];
  int                 table_count;
  sktab_pkg::result_t expected_results [$];
  int                 mismatch_count;
  bit                 idle_on;

  sorted_key_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic sktab_pkg::result_t table_predict(sktab_pkg::item_t it);
    sktab_pkg::result_t r;
    int                 slot;
    int                 i;
    logic               hit;
    r = '0;
    slot = 0;
    while (slot < table_count && table_keys[slot] < it.entry_key) slot++;
    hit = (slot < table_count) && (table_keys[slot] == it.entry_key);
    if (it.kind == sktab_pkg::KIND_FIND) begin
      if (hit) begin
        r.status = sktab_pkg::ST_FOUND;
        r.found_handle = table_handles[slot];
        r.position = slot[3:0];
      end else begin
        r.status = sktab_pkg::ST_NOT_FOUND;
      end
    end else if (hit) begin
      r.status = sktab_pkg::ST_DUPLICATE;
    end else if (table_count >= TABLE_DEPTH) begin
      r.status = sktab_pkg::ST_FULL;
    end else begin
      for (i = table_count; i > slot; i--) begin
        table_keys[i] = table_keys[i - 1];
        table_handles[i] = table_handles[i - 1];
      end
      table_keys[slot] = it.entry_key;
      table_handles[slot] = it.entry_handle;
      table_count++;
      r.status = sktab_pkg::ST_INSERTED;
      r.position = slot[3:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] stored_key();
    return table_keys[$urandom_range(0, table_count - 1)];
  endfunction

  // one transaction: optional idle gap, then hold start until accepted
  task automatic send_item(logic kind, logic [15:0] key, logic [7:0] handle);
    sktab_pkg::item_t it;
    int               gap;
    it.kind = kind;
    it.entry_key = key;
    it.entry_handle = handle;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    repeat (gap) @(negedge clk) start = 1'b0;
    @(negedge clk);
    start = 1'b1;
    item = it;
    forever begin
      @(posedge clk);
      if (busy === 1'b0) break;
    end
    expected_results.push_back(table_predict(it));
  endtask

  task automatic wait_table_idle();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    sktab_pkg::result_t want;
    if (rst === 1'b0 && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: status %0d handle %02h position %0d",
                   result.status, result.found_handle, result.position);
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status || result.found_handle !== want.found_handle ||
            result.position !== want.position) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d handle %02h position %0d, got %0d %02h %0d",
                     want.status, want.found_handle, want.position,
                     result.status, result.found_handle, result.position);
        end
      end
    end
  end

  task automatic test_empty_find();
    idle_on = 1'b1;
    send_item(sktab_pkg::KIND_FIND, 16'h0000, 8'hff);
    send_item(sktab_pkg::KIND_FIND, 16'hffff, 8'h00);
  endtask

  task automatic test_ordered_insert();
    idle_on = 1'($urandom_range(0, 1));
    send_item(sktab_pkg::KIND_INSERT, 16'h8000, 8'h5a);
    send_item(sktab_pkg::KIND_INSERT, 16'h0000, 8'hff);
    send_item(sktab_pkg::KIND_INSERT, 16'hffff, 8'h00);
    send_item(sktab_pkg::KIND_INSERT, 16'h4000, 8'ha5);
    send_item(sktab_pkg::KIND_INSERT, 16'h8000, 8'h33);
    send_item(sktab_pkg::KIND_FIND, 16'h0000, 8'h00);
    send_item(sktab_pkg::KIND_FIND, 16'hffff, 8'hff);
    send_item(sktab_pkg::KIND_FIND, 16'h4000, 8'h00);
    send_item(sktab_pkg::KIND_FIND, 16'h4001, 8'h00);
    send_item(sktab_pkg::KIND_FIND, 16'h7fff, 8'hff);
  endtask

  task automatic test_random_fill();
    int n;
    int pick;
    n = 0;
    while (table_count < TABLE_DEPTH) begin
      if (n % 8 == 0) idle_on = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick < 5)
        send_item(sktab_pkg::KIND_INSERT, 16'($urandom), 8'($urandom));
      else if (pick == 5)
        send_item(sktab_pkg::KIND_INSERT, stored_key(), 8'($urandom));
      else if (pick < 8)
        send_item(sktab_pkg::KIND_FIND, stored_key(), 8'($urandom));
      else
        send_item(sktab_pkg::KIND_FIND, 16'($urandom), 8'($urandom));
      n++;
    end
  endtask

  task automatic test_full_table();
    logic [15:0] absent;
    bit          present;
    idle_on = 1'b0;
    do begin
      absent = 16'($urandom);
      present = 1'b0;
      foreach (table_keys[j]) if (table_keys[j] == absent) present = 1'b1;
    end while (present);
    send_item(sktab_pkg::KIND_INSERT, absent, 8'h77);
    send_item(sktab_pkg::KIND_INSERT, 16'h0000, 8'h11);
    send_item(sktab_pkg::KIND_INSERT, 16'hffff, 8'h22);
    send_item(sktab_pkg::KIND_FIND, 16'h0000, 8'h00);
    send_item(sktab_pkg::KIND_FIND, 16'hffff, 8'h00);
  endtask

  task automatic test_random_lookup();
    int pick;
    for (int n = 0; n < LOOKUP_ITEMS; n++) begin
      if (n % 40 == 0) idle_on = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 19);
      if (pick < 8)
        send_item(sktab_pkg::KIND_FIND, stored_key(), 8'($urandom));
      else if (pick < 11)
        send_item(sktab_pkg::KIND_FIND, 16'($urandom), 8'($urandom));
      else if (pick == 11)
        send_item(sktab_pkg::KIND_FIND, $urandom_range(0, 1) ? 16'hffff : 16'h0000,
                  8'($urandom));
      else if (pick < 14)
        send_item(sktab_pkg::KIND_FIND,
                  stored_key() + ($urandom_range(0, 1) ? 16'h0001 : 16'hffff),
                  8'($urandom));
      else if (pick < 17)
        send_item(sktab_pkg::KIND_INSERT, 16'($urandom), 8'($urandom));
      else
        send_item(sktab_pkg::KIND_INSERT, stored_key(), 8'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    table_count = 0;
    mismatch_count = 0;
    idle_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_find();
    wait_table_idle();
    test_ordered_insert();
    wait_table_idle();
    test_random_fill();
    wait_table_idle();
    test_full_table();
    wait_table_idle();
    test_random_lookup();
    wait_table_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
